/* hw/rtl/double_ended_queue_with_reverse_macros.svh */
// assertion macros shared by the deque rtl
`ifndef DOUBLE_ENDED_QUEUE_WITH_REVERSE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_REVERSE_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising clock edge out of reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/deq_rev_pkg.sv */
package deq_rev_pkg;

    // storage geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 64;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int FIELD_W  = 64;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // derived widths
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = $clog2(2 * CAPACITY + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_REVERSE   = 3'd4,
        OP_QUERY     = 3'd5
    } t_op;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // ring index plus offset, offset at most CAPACITY
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // ring index step forward
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] base);
        return (base == LAST_IDX) ? '0 : base + IDX_W'(1);
    endfunction

    // ring index step backward
    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] base);
        return (base == '0) ? LAST_IDX : base - IDX_W'(1);
    endfunction

endpackage

/* hw/rtl/double_ended_queue_with_reverse.sv */
// Bounded double-ended queue with constant-time reversal.
// Input channel: i_valid / o_stall carry one transaction of i_operation and
// i_value (add front, add back, remove front, remove back, reverse, query).
// Output channel: o_valid / i_stall carry one result transaction per input:
// status, logical front and back values (zero when empty), occupancy, empty.
// Values live in a ring memory with two registered read ports; a head index,
// a count and a direction flag sit in flip-flops. Reverse flips the flag.
// Each transaction makes a write-then-read pass through the ring memory: the
// update is made when the input is taken, state S_READ then reads both
// physical ends, and state S_RESP then raises o_valid with the result.
// A new input is taken in the cycle its predecessor's result is taken.
// While the receiver stalls, the result holds and o_stall stays high.
// Reset (synchronous, active low) empties the deque and clears the flag;
// memory contents are not cleared and are never reported until written.
// Refused operations (underflow, overflow) leave the state unchanged.
`include "double_ended_queue_with_reverse_macros.svh"

module double_ended_queue_with_reverse (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [deq_rev_pkg::OP_W-1:0]            i_operation,
    input  logic [deq_rev_pkg::FIELD_W-1:0]         i_value,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [deq_rev_pkg::STATUS_W-1:0]        o_status,
    output logic [deq_rev_pkg::FIELD_W-1:0]         o_front_value,
    output logic [deq_rev_pkg::FIELD_W-1:0]         o_back_value,
    output logic [deq_rev_pkg::OCC_W-1:0]           o_occupancy,
    output logic                                    o_is_empty
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [deq_rev_pkg::IDX_W-1:0]      r_head, n_head;
    logic [deq_rev_pkg::CNT_W-1:0]      r_count, n_count;
    logic                               r_rev, n_rev;
    deq_rev_pkg::t_status               r_status, n_status;

    logic [deq_rev_pkg::DATA_WIDTH-1:0] mem [deq_rev_pkg::CAPACITY];
    logic [deq_rev_pkg::DATA_WIDTH-1:0] r_rd_first, r_rd_last;

    logic                               wr_en;
    logic [deq_rev_pkg::IDX_W-1:0]      wr_addr;
    logic [deq_rev_pkg::IDX_W-1:0]      rd_addr_last;
    logic                               in_acc, out_acc;
    logic                               is_empty, is_full, at_first;
    deq_rev_pkg::t_op                   op;

    // handshakes
    assign o_valid = (r_state == S_RESP);
    assign out_acc = o_valid && !i_stall;
    assign o_stall = !((r_state == S_IDLE) || out_acc);
    assign in_acc  = i_valid && !o_stall;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= deq_rev_pkg::FULL_CNT);
    assign op       = deq_rev_pkg::t_op'(i_operation);

    // operation decode and pointer update
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = deq_rev_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = deq_rev_pkg::wrap_add(r_head, r_count);
        at_first = 1'b0;
        case (op)
            deq_rev_pkg::OP_ADD_FRONT, deq_rev_pkg::OP_ADD_BACK: begin
                at_first = (op == deq_rev_pkg::OP_ADD_FRONT) != r_rev;
                if (is_full) begin
                    n_status = deq_rev_pkg::ST_OVER;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + deq_rev_pkg::CNT_W'(1);
                    if (at_first) begin
                        n_head  = deq_rev_pkg::wrap_dec(r_head);
                        wr_addr = deq_rev_pkg::wrap_dec(r_head);
                    end
                end
            end
            deq_rev_pkg::OP_REM_FRONT, deq_rev_pkg::OP_REM_BACK: begin
                at_first = (op == deq_rev_pkg::OP_REM_FRONT) != r_rev;
                if (is_empty) begin
                    n_status = deq_rev_pkg::ST_UNDER;
                end else begin
                    n_count = r_count - deq_rev_pkg::CNT_W'(1);
                    if (at_first) begin
                        n_head = deq_rev_pkg::wrap_inc(r_head);
                    end
                end
            end
            deq_rev_pkg::OP_REVERSE: begin
                if (is_empty) begin
                    n_status = deq_rev_pkg::ST_UNDER;
                end else begin
                    n_rev = !r_rev;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_READ;
            S_READ: n_state = S_RESP;
            S_RESP: begin
                if (in_acc) begin
                    n_state = S_READ;
                end else if (out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_rev   <= n_rev;
            end
        end
    end

    // status held with the transaction
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
        end
    end

    // ring memory write port
    always_ff @(posedge i_clk) begin
        if (in_acc && wr_en) begin
            mem[wr_addr] <= i_value[deq_rev_pkg::DATA_WIDTH-1:0];
        end
    end

    // two registered read ports at the physical ends
    assign rd_addr_last = deq_rev_pkg::wrap_add(r_head, r_count - deq_rev_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_first <= mem[r_head];
            r_rd_last  <= mem[rd_addr_last];
        end
    end

    // result fields
    assign o_status      = r_status;
    assign o_is_empty    = is_empty;
    assign o_occupancy   = deq_rev_pkg::OCC_W'(r_count);
    assign o_front_value = is_empty ? '0 :
                           deq_rev_pkg::FIELD_W'(r_rev ? r_rd_last : r_rd_first);
    assign o_back_value  = is_empty ? '0 :
                           deq_rev_pkg::FIELD_W'(r_rev ? r_rd_first : r_rd_last);

    // checks
    `DEQ_ASSERT_NEXT(a_acc_to_read, i_clk, i_rst_n, in_acc, r_state == S_READ,
        "accepted transaction did not start a read")
    `DEQ_ASSERT_NEXT(a_read_to_resp, i_clk, i_rst_n, r_state == S_READ, o_valid,
        "read pass did not produce a result")
    `DEQ_ASSERT_NOW(a_over_full, i_clk, i_rst_n,
        o_valid && (r_status == deq_rev_pkg::ST_OVER), r_count == deq_rev_pkg::FULL_CNT,
        "overflow reported while not full")
    `DEQ_ASSERT_NOW(a_under_empty, i_clk, i_rst_n,
        o_valid && (r_status == deq_rev_pkg::ST_UNDER), is_empty,
        "underflow reported while not empty")

endmodule
